/* rtl/core/fmlc_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fmlc_pkg
// Shared types and constants for the leaky-counter fault monitor.
// ----------------------------------------------------------------------------
package fmlc_pkg;

    // command codes
    typedef enum logic [1:0] {
        CMD_CHECK = 2'd0,
        CMD_HALT  = 2'd1,
        CMD_ESTOP = 2'd2,
        CMD_CLEAR = 2'd3
    } cmd_t;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_CHECK_ENABLE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MOTOR_MIN    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MOTOR_MAX    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LOGIC_MIN    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FAULT_LIMIT  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_HALT_TICKS   = 3'd5;

    // register reset values
    localparam logic [3:0]  CHECK_ENABLE_RST = 4'd15;
    localparam logic [15:0] FAULT_LIMIT_RST  = 16'd500;
    localparam logic [7:0]  HALT_TICKS_RST   = 8'd100;

    // check enable bits
    localparam int unsigned EN_LIMIT = 0;
    localparam int unsigned EN_MOTOR = 1;
    localparam int unsigned EN_LOGIC = 2;
    localparam int unsigned EN_AMP   = 3;

    // sticky flag bits
    localparam int unsigned FLAG_ESTOP = 0;
    localparam int unsigned FLAG_LIMIT = 1;
    localparam int unsigned FLAG_MOTOR = 2;
    localparam int unsigned FLAG_LOGIC = 3;
    localparam int unsigned FLAG_AMP   = 4;

    localparam logic [15:0] COUNT_MAX = 16'hFFFF;
    localparam logic [7:0]  DAMP_MAX  = 8'hFF;

    typedef struct packed {
        logic [1:0]  command;
        logic [7:0]  limit_switches;
        logic [11:0] motor_voltage;
        logic [11:0] logic_voltage;
        logic [1:0]  amp_faults;
    } sample_t;

    typedef struct packed {
        logic       error;
        logic [4:0] error_flags;
        logic       halt_active;
    } result_t;

endpackage
`default_nettype wire

/* rtl/core/fmlc_in_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fmlc_in_if
// Valid/ready channel carrying one sample word into the monitor.
// ----------------------------------------------------------------------------
interface fmlc_in_if;
    logic              valid;
    logic              ready;
    fmlc_pkg::sample_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

/* rtl/core/fmlc_out_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fmlc_out_if
// Valid/ready channel carrying one result word out of the monitor.
// ----------------------------------------------------------------------------
interface fmlc_out_if;
    logic              valid;
    logic              ready;
    fmlc_pkg::result_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

/* rtl/core/fault_monitor_leaky_counters_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fault_monitor_leaky_counters_core
// Motor-drive fault monitor with leaky voltage fault counters.
//
// Channels: sample (sink) takes one command word with the limit switch,
// voltage and amplifier inputs; result (source) gives one word per sample
// with error, the sticky error flags and halt_active. A word is moved when
// valid and ready are both high at a rising edge of clk.
// Configuration: cfg_we/cfg_index/cfg_data write one register per cycle;
// write only while no sample is in flight.
// Result: valid in the cycle after the sample is taken.
// Throughput: one sample per cycle while no result is held back; the
// counters and flags are updated in the accepting cycle by a single
// increment and compare, so the next sample sees them at once.
// Stall: the result register holds while result.ready is low; sample.ready
// drops only while a result is held and not being taken.
// Reset (rst_n low, asynchronous): counters, flags and the result valid
// clear; registers return to check_enable 15, fault_count_limit 500,
// halt_ticks 100, all thresholds 0.
// ----------------------------------------------------------------------------
module fault_monitor_leaky_counters_core (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    fmlc_in_if.sink                                  sample,
    fmlc_out_if.source                               result,
    input  wire logic                                cfg_we,
    input  wire logic [fmlc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [fmlc_pkg::CFG_DATA_W-1:0]     cfg_data
);

    // configuration
    logic [3:0]  check_enable_reg;
    logic [11:0] motor_min_reg;
    logic [11:0] motor_max_reg;
    logic [11:0] logic_min_reg;
    logic [15:0] fault_limit_reg;
    logic [7:0]  halt_ticks_reg;

    // state
    logic [15:0] motor_count_reg, motor_count_next;
    logic [15:0] logic_count_reg, logic_count_next;
    logic [7:0]  damp_count_reg,  damp_count_next;
    logic [4:0]  flags_reg,       flags_next;

    // result register
    logic              out_valid_reg;
    fmlc_pkg::result_t out_data_reg, out_data_next;

    logic accept;
    logic motor_danger, logic_danger;
    logic [15:0] motor_leak, logic_leak;
    logic [7:0]  damp_inc;

    assign sample.ready = !out_valid_reg || result.ready;
    assign accept       = sample.valid && sample.ready;
    assign result.valid = out_valid_reg;
    assign result.data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            check_enable_reg <= fmlc_pkg::CHECK_ENABLE_RST;
            motor_min_reg    <= '0;
            motor_max_reg    <= '0;
            logic_min_reg    <= '0;
            fault_limit_reg  <= fmlc_pkg::FAULT_LIMIT_RST;
            halt_ticks_reg   <= fmlc_pkg::HALT_TICKS_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                fmlc_pkg::CFG_CHECK_ENABLE: check_enable_reg <= cfg_data[3:0];
                fmlc_pkg::CFG_MOTOR_MIN:    motor_min_reg    <= cfg_data[11:0];
                fmlc_pkg::CFG_MOTOR_MAX:    motor_max_reg    <= cfg_data[11:0];
                fmlc_pkg::CFG_LOGIC_MIN:    logic_min_reg    <= cfg_data[11:0];
                fmlc_pkg::CFG_FAULT_LIMIT:  fault_limit_reg  <= cfg_data[15:0];
                fmlc_pkg::CFG_HALT_TICKS:   halt_ticks_reg   <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // leaky counters: rise saturating while in danger, else fall toward zero
    assign motor_danger = (sample.data.motor_voltage < motor_max_reg) &&
                          (sample.data.motor_voltage > motor_min_reg);
    assign logic_danger = sample.data.logic_voltage < logic_min_reg;

    always_comb
    begin
        if (motor_danger)
            motor_leak = (motor_count_reg != fmlc_pkg::COUNT_MAX) ?
                         motor_count_reg + 16'd1 : motor_count_reg;
        else
            motor_leak = (motor_count_reg != '0) ? motor_count_reg - 16'd1 : '0;

        if (logic_danger)
            logic_leak = (logic_count_reg != fmlc_pkg::COUNT_MAX) ?
                         logic_count_reg + 16'd1 : logic_count_reg;
        else
            logic_leak = (logic_count_reg != '0) ? logic_count_reg - 16'd1 : '0;

        damp_inc = (damp_count_reg != fmlc_pkg::DAMP_MAX) ?
                   damp_count_reg + 8'd1 : damp_count_reg;
    end

    always_comb
    begin
        motor_count_next = motor_count_reg;
        logic_count_next = logic_count_reg;
        damp_count_next  = damp_count_reg;
        flags_next       = flags_reg;
        out_data_next    = '0;

        unique case (fmlc_pkg::cmd_t'(sample.data.command))
            fmlc_pkg::CMD_CHECK:
            begin
                if (check_enable_reg[fmlc_pkg::EN_LIMIT] &&
                    (sample.data.limit_switches != '0))
                begin
                    // limit pressed: flag and stop, counters untouched
                    flags_next[fmlc_pkg::FLAG_LIMIT] = 1'b1;
                    out_data_next.error              = 1'b1;
                end
                else if (check_enable_reg[fmlc_pkg::EN_MOTOR] &&
                         (motor_leak > fault_limit_reg))
                begin
                    motor_count_next                 = motor_leak;
                    flags_next[fmlc_pkg::FLAG_MOTOR] = 1'b1;
                    out_data_next.error              = 1'b1;
                end
                else
                begin
                    if (check_enable_reg[fmlc_pkg::EN_MOTOR])
                        motor_count_next = motor_leak;
                    if (check_enable_reg[fmlc_pkg::EN_LOGIC] &&
                        (logic_leak > fault_limit_reg))
                    begin
                        logic_count_next                 = logic_leak;
                        flags_next[fmlc_pkg::FLAG_LOGIC] = 1'b1;
                        out_data_next.error              = 1'b1;
                    end
                    else
                    begin
                        if (check_enable_reg[fmlc_pkg::EN_LOGIC])
                            logic_count_next = logic_leak;
                        // amplifier fault flags but does not stop
                        if (check_enable_reg[fmlc_pkg::EN_AMP] &&
                            (sample.data.amp_faults != '0))
                            flags_next[fmlc_pkg::FLAG_AMP] = 1'b1;
                    end
                end
            end
            fmlc_pkg::CMD_HALT:
            begin
                damp_count_next           = damp_inc;
                out_data_next.halt_active = (damp_inc <= halt_ticks_reg);
            end
            fmlc_pkg::CMD_ESTOP:
            begin
                flags_next[fmlc_pkg::FLAG_ESTOP] = 1'b1;
            end
            fmlc_pkg::CMD_CLEAR:
            begin
                flags_next       = '0;
                motor_count_next = '0;
                logic_count_next = '0;
                damp_count_next  = '0;
            end
            default: ;
        endcase

        out_data_next.error_flags = flags_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            motor_count_reg <= '0;
            logic_count_reg <= '0;
            damp_count_reg  <= '0;
            flags_reg       <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                motor_count_reg <= motor_count_next;
                logic_count_reg <= logic_count_next;
                damp_count_reg  <= damp_count_next;
                flags_reg       <= flags_next;
                out_valid_reg   <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload: load on accept, hold otherwise
    always_ff @(posedge clk)
    begin
        if (accept)
            out_data_reg <= out_data_next;
    end

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    a_clear_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (sample.data.command == fmlc_pkg::CMD_CLEAR)) |=>
        (result.valid && (result.data.error_flags == '0) &&
         (motor_count_reg == '0) && (logic_count_reg == '0) &&
         (damp_count_reg == '0)))
        else $error("clear did not zero flags and counters");

    a_error_only_check: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (sample.data.command != fmlc_pkg::CMD_CHECK)) |=>
        !result.data.error)
        else $error("error raised on a non-check command");

    a_halt_only_tick: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (sample.data.command != fmlc_pkg::CMD_HALT)) |=>
        !result.data.halt_active)
        else $error("halt_active raised on a non-halt command");

    a_flags_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        !(accept && (sample.data.command == fmlc_pkg::CMD_CLEAR)) |=>
        ((flags_reg & $past(flags_reg)) == $past(flags_reg)))
        else $error("sticky flag dropped without clear");

    a_motor_no_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        ((motor_count_reg == fmlc_pkg::COUNT_MAX) &&
         !(accept && (sample.data.command == fmlc_pkg::CMD_CLEAR))) |=>
        (motor_count_reg != '0))
        else $error("motor fault counter wrapped");

endmodule
`default_nettype wire
